// ----- hdl/olmt_pkg.sv -----
`default_nettype none

package olmt_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned STATUS_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic match;
    logic apply;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_hold;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/olmt_if.sv -----
`default_nettype none

// Command channel
interface olmt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [olmt_pkg::ACT_W-1:0]     action;
  logic signed [olmt_pkg::ID_W-1:0]      item_id;

  modport source (output valid, output action, output item_id, input ready);
  modport sink   (input valid, input action, input item_id, output ready);
endinterface

// Result channel
interface olmt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  middle_valid;
  logic signed [olmt_pkg::ID_W-1:0]      middle_id;
  logic        [olmt_pkg::CNT_W-1:0]     entry_count;
  logic        [olmt_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output middle_valid, output middle_id,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input middle_valid, input middle_id,
                  input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/olmt_ctrl.sv -----
`default_nettype none

module olmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire olmt_pkg::sts_t sts,
  output olmt_pkg::cmd_t     cmd
);

  olmt_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olmt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      olmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = olmt_pkg::S_MATCH;
        end
      end
      olmt_pkg::S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = olmt_pkg::S_APPLY;
      end
      olmt_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = olmt_pkg::S_OUT;
      end
      olmt_pkg::S_OUT: begin
        // wait for the output register to free up
        if (!sts.out_hold) begin
          cmd.load_out = 1'b1;
          state_nxt    = olmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olmt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/olmt_dp.sv -----
`default_nettype none

module olmt_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire olmt_pkg::cmd_t                        cmd,
  output olmt_pkg::sts_t                             sts,
  input  wire logic        [olmt_pkg::ACT_W-1:0]     in_action,
  input  wire logic signed [olmt_pkg::ID_W-1:0]      in_item_id,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       out_middle_valid,
  output logic signed      [olmt_pkg::ID_W-1:0]      out_middle_id,
  output logic             [olmt_pkg::CNT_W-1:0]     out_entry_count,
  output logic             [olmt_pkg::STATUS_W-1:0]  out_status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  // Captured item
  logic        [olmt_pkg::ACT_W-1:0]    act_r;
  logic signed [olmt_pkg::ID_W-1:0]     id_r;

  // List cells and fill count
  logic signed [olmt_pkg::ID_W-1:0]     cells_r   [CAPACITY];
  logic signed [olmt_pkg::ID_W-1:0]     cells_nxt [CAPACITY];
  logic        [CW-1:0]                 count_r, count_nxt;

  // Match vector from the broadcast compare
  logic        [CAPACITY-1:0]           match_r, match_nxt;
  logic                                 hit_r;
  logic        [olmt_pkg::STATUS_W-1:0] st_r, st_nxt;

  // Output register
  logic                                 out_valid_r;
  logic                                 mid_valid_r;
  logic signed [olmt_pkg::ID_W-1:0]     mid_id_r;
  logic        [olmt_pkg::CNT_W-1:0]    ent_cnt_r;
  logic        [olmt_pkg::STATUS_W-1:0] out_st_r;

  // Parallel prefix OR of the match vector: marks cells at and after the first hit
  logic        [CAPACITY-1:0]           pre [IW+1];

  logic                                 full;
  logic        [CW-1:0]                 mid_cnt;
  logic        [CW+olmt_pkg::CNT_W-1:0] cnt_ext;

  // Broadcast compare against the live cells
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (CW'(i) < count_r) && (cells_r[i] == id_r);
    end
  end

  always_comb begin
    pre[0] = match_r;
    for (int l = 0; l < IW; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        pre[l+1][i] = pre[l][i];
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end
      end
    end
  end

  assign full = (count_r == CW'(CAPACITY));

  // Append, delete with gap closing, or no change
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    count_nxt = count_r;
    st_nxt    = olmt_pkg::ST_DONE;
    case (act_r)
      olmt_pkg::ACT_APPEND: begin
        if (full) begin
          st_nxt = olmt_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == count_r) begin
              cells_nxt[i] = id_r;
            end
          end
          count_nxt = count_r + CW'(1);
        end
      end
      olmt_pkg::ACT_DELETE: begin
        if (!hit_r) begin
          st_nxt = olmt_pkg::ST_MISS;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (pre[IW][i]) begin
              cells_nxt[i] = cells_r[i+1];
            end
          end
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        // query and unused codes leave the list alone
        st_nxt = olmt_pkg::ST_DONE;
      end
    endcase
  end

  // Item capture and list update
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      id_r  <= in_item_id;
    end
    if (cmd.match) begin
      match_r <= match_nxt;
      hit_r   <= |match_nxt;
    end
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  // Middle cell at index count/2
  assign mid_cnt = count_r >> 1;
  assign cnt_ext = {{olmt_pkg::CNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mid_valid_r <= (count_r != '0);
      mid_id_r    <= (count_r != '0) ? cells_r[mid_cnt[IW-1:0]] : '0;
      ent_cnt_r   <= cnt_ext[olmt_pkg::CNT_W-1:0];
      out_st_r    <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_hold     = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_middle_valid = mid_valid_r;
  assign out_middle_id    = mid_id_r;
  assign out_entry_count  = ent_cnt_r;
  assign out_status       = out_st_r;

endmodule

`default_nettype wire

// ----- hdl/ordered_list_middle_tracker.sv -----
`default_nettype none
// Ordered list middle tracker.
// in_ch carries one command item: action (append, delete first match,
// query) and item_id. out_ch returns one result item per command: the
// entry count, the entry at index count/2 with its valid flag, and a
// status code (done, list full, delete miss).
// The list is a row of CAPACITY cells. A delete compares item_id against
// every cell at once and shifts the cells behind the first hit down by one.
// Timing: an item is taken in the idle state, the compare runs in the match
// state, the update in the apply state, and the result is loaded into the
// output register in the out state once that register is free; in_ch.ready
// is high again once the result is loaded.
// A result waits in the output register until taken; while it waits the
// next item is accepted and worked on, and its result is held back (and
// in_ch stays not ready) until the earlier result leaves.
// Reset empties the list and drops any pending result; cell contents are
// not cleared and are never seen before being written.
module ordered_list_middle_tracker #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olmt_in_if.sink     in_ch,
  olmt_out_if.source  out_ch
);

  olmt_pkg::cmd_t cmd;
  olmt_pkg::sts_t sts;

  olmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olmt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_item_id       (in_ch.item_id),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_middle_valid (out_ch.middle_valid),
    .out_middle_id    (out_ch.middle_id),
    .out_entry_count  (out_ch.entry_count),
    .out_status       (out_ch.status)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;

  localparam int unsigned LIST_CAP    = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 450;

  // Spare action code; the block treats it like a query
  localparam logic [olmt_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [olmt_pkg::ACT_W-1:0]       action;
    logic signed [olmt_pkg::ID_W-1:0] id;
  } command_t;

  typedef struct {
    logic                             mid_valid;
    logic signed [olmt_pkg::ID_W-1:0] mid_id;
    logic [olmt_pkg::CNT_W-1:0]       count;
    logic [olmt_pkg::STATUS_W-1:0]    status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  olmt_in_if  in_ch ();
  olmt_out_if out_ch ();

  ordered_list_middle_tracker #(.CAPACITY(LIST_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list
  logic signed [olmt_pkg::ID_W-1:0] shadow_ids [LIST_CAP];
  int unsigned                      shadow_len = 0;

  command_t pending_commands[$];
  answer_t  awaited_answers[$];

  int unsigned send_mode  [4] = '{0, 81, 0, 11};
  int unsigned stall_mode [4] = '{0, 0, 81, 11};

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned answers_seen = 0;
  int unsigned drops_seen   = 0;
  int unsigned misses_seen  = 0;
  int unsigned full_answers = 0;
  int unsigned cycles       = 0;

  logic signed [olmt_pkg::ID_W-1:0] id_pool [16] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
    32'sd1, 32'sd2, 32'sd3, 32'sd5, 32'sd8, 32'sd13, 32'sd21, 32'sd34,
    32'sh5555_5555, 32'shaaaa_aaaa, 32'sd100, -32'sd100
  };

  command_t offered;

  // Apply one command to the shadow list and work out its answer
  function automatic answer_t track_command(command_t c);
    answer_t a;
    int      hit;
    a.status = olmt_pkg::ST_DONE;
    if (c.action == olmt_pkg::ACT_APPEND) begin
      if (shadow_len >= LIST_CAP) begin
        a.status = olmt_pkg::ST_FULL;
      end else begin
        shadow_ids[shadow_len] = c.id;
        shadow_len++;
      end
    end else if (c.action == olmt_pkg::ACT_DELETE) begin
      hit = -1;
      for (int i = 0; i < shadow_len; i++) begin
        if (hit < 0 && shadow_ids[i] == c.id) hit = i;
      end
      if (hit < 0) begin
        a.status = olmt_pkg::ST_MISS;
      end else begin
        for (int i = hit; i + 1 < shadow_len; i++) shadow_ids[i] = shadow_ids[i + 1];
        shadow_len--;
      end
    end
    a.mid_valid = (shadow_len != 0);
    a.mid_id    = (shadow_len != 0) ? shadow_ids[shadow_len / 2] : '0;
    a.count     = shadow_len[olmt_pkg::CNT_W-1:0];
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("tb: mismatch in %s at result %0d: got %h, want %h",
             what, answers_seen, got, want);
  endtask

  task automatic queue_command(input logic [olmt_pkg::ACT_W-1:0] action,
                               input logic signed [olmt_pkg::ID_W-1:0] id);
    command_t c;
    c.action = action;
    c.id     = id;
    pending_commands.push_back(c);
  endtask

  // Mostly ids from a small pool so deletes hit; some fully random ids
  function automatic command_t random_command(int unsigned append_pct);
    command_t    c;
    int unsigned r;
    r = $urandom_range(99);
    if (r < append_pct)
      c.action = olmt_pkg::ACT_APPEND;
    else if (r < append_pct + (100 - append_pct) * 3 / 5)
      c.action = olmt_pkg::ACT_DELETE;
    else if (r < 95)
      c.action = olmt_pkg::ACT_QUERY;
    else
      c.action = ACT_SPARE;
    if ($urandom_range(9) == 0)
      c.id = $urandom;
    else
      c.id = id_pool[$urandom_range(15)];
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_commands.size() != 0 || in_ch.valid || awaited_answers.size() != 0)
      @(negedge clk);
  endtask

  // Driver: presents queued items, predicts each accepted one
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.action  <= olmt_pkg::ACT_QUERY;
      in_ch.item_id <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        a = track_command(offered);
        awaited_answers.push_back(a);
        items_sent++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_commands.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.action  <= offered.action;
          in_ch.item_id <= offered.id;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result item against the oldest prediction
  always @(posedge clk) begin
    answer_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        if (awaited_answers.size() == 0) begin
          flag_mismatch("unexpected result", 32'(out_ch.entry_count), '0);
        end else begin
          w = awaited_answers.pop_front();
          if (out_ch.middle_valid !== w.mid_valid)
            flag_mismatch("middle_valid", 32'(out_ch.middle_valid), 32'(w.mid_valid));
          if (out_ch.middle_id !== w.mid_id)
            flag_mismatch("middle_id", out_ch.middle_id, w.mid_id);
          if (out_ch.entry_count !== w.count)
            flag_mismatch("entry_count", 32'(out_ch.entry_count), 32'(w.count));
          if (out_ch.status !== w.status)
            flag_mismatch("status", 32'(out_ch.status), 32'(w.status));
          if (w.status == olmt_pkg::ST_FULL) drops_seen++;
          if (w.status == olmt_pkg::ST_MISS) misses_seen++;
          if (w.count == LIST_CAP) full_answers++;
        end
      end
      // Hold off while a long stall is pending or running, else random stalls
      if (hold_served != hold_requests || hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned append_pct;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, fill to capacity, drop, deletes
    queue_command(olmt_pkg::ACT_QUERY, 32'sd9);
    queue_command(olmt_pkg::ACT_DELETE, 32'sd5);
    queue_command(ACT_SPARE, -32'sd1);
    queue_command(olmt_pkg::ACT_APPEND, 32'sh8000_0000);
    queue_command(olmt_pkg::ACT_APPEND, 32'sh7fff_ffff);
    queue_command(olmt_pkg::ACT_APPEND, 32'sd0);
    queue_command(olmt_pkg::ACT_APPEND, -32'sd1);
    for (int i = 0; i < 12; i++)
      queue_command(olmt_pkg::ACT_APPEND, (i % 5 == 0) ? 32'sd7 : 32'sd40 + i);
    queue_command(olmt_pkg::ACT_APPEND, 32'sd99);
    queue_command(olmt_pkg::ACT_DELETE, 32'sd7);
    queue_command(olmt_pkg::ACT_DELETE, 32'sd12345);
    queue_command(olmt_pkg::ACT_DELETE, 32'sd51);
    queue_command(olmt_pkg::ACT_DELETE, 32'sh8000_0000);
    queue_command(ACT_SPARE, 32'sh7fff_ffff);
    wait_drained();

    // Random phases with different idling on each side
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mode[p];
      recv_stall_pct = stall_mode[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) append_pct = $urandom_range(25, 85);
        pending_commands.push_back(random_command(append_pct));
      end
      // Long receiver hold-off while the sender keeps offering
      if (p == 0) begin
        repeat (30) @(posedge clk);
        hold_requests++;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d items sent, %0d results checked, %0d with a full list",
             items_sent, answers_seen, full_answers);
    $display("tb: %0d dropped appends, %0d delete misses, %0d mismatches",
             drops_seen, misses_seen, mismatches);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/olmt_pkg.sv
hdl/olmt_if.sv
hdl/olmt_ctrl.sv
hdl/olmt_dp.sv
hdl/ordered_list_middle_tracker.sv
dv/tb.sv
